@@ rtl/rqm_pkg.sv @@
// Shared types and constants of the priority run-queue manager.
// Holds field widths, operation codes and status codes.
// No dependencies.
`default_nettype none

package rqm_pkg;

  // Field widths of an input item and of a result item.
  localparam int OP_W     = 2;
  localparam int TASK_W   = 6;
  localparam int PRIO_W   = 4;
  localparam int STAT_W   = 3;
  localparam int QCNT_W   = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [TASK_W-1:0] task_t;
  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [STAT_W-1:0] stat_t;

  // Operation codes.
  localparam op_t OP_ENQUEUE = 2'd0;
  localparam op_t OP_DEQUEUE = 2'd1;
  localparam op_t OP_REMOVE  = 2'd2;
  localparam op_t OP_MOVE    = 2'd3;

  // Status codes.
  localparam stat_t ST_OK        = 3'd0;
  localparam stat_t ST_BAD_PRIO  = 3'd1;
  localparam stat_t ST_IDLE      = 3'd2;
  localparam stat_t ST_QUEUED    = 3'd3;
  localparam stat_t ST_NOT_FOUND = 3'd4;

  // The idle task.
  localparam task_t IDLE_TASK = '0;

endpackage

`default_nettype wire

@@ rtl/priority_run_queue_manager_top.sv @@
// Priority run-queue manager: one linked FIFO of task ids per priority level.
// Depends on rqm_pkg for widths and codes.
//
//   Channel   Direction  Handshake           Payload
//   in_       slave      tvalid/tready       op, task_id, priority_req, target_prio
//   out_      master     tvalid/tready       status, out_task, queue_count
//
// Enqueue finishes in the decode state. Dequeue reads the head's link and then takes the head,
// dropping any idle task found at the head. Removal unlinks a task at the head directly, else
// walks link by link until it finds the task or the count runs out. A move then appends it.
// After reset the counts clear at once and a pass over the queued flags, one entry per task
// slot (at most 64), clears them, with the input held not ready until it ends.
// A new item is accepted while a result waits in the output register; the block holds
// its next result back, and the input with it, only while the output side stalls.
`default_nettype none

module priority_run_queue_manager_top
  import rqm_pkg::*;
#(
  parameter int PRIORITY_LEVELS = 8,
  parameter int TASK_SLOTS      = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [1:0] operation, [7:2] task_id, [11:8] priority_req, [15:12] target_prio
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] status, [8:3] out_task, [15:9] queue_count
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int AW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int NF = (TASK_SLOTS < (2 ** TASK_W)) ? TASK_SLOTS : (2 ** TASK_W);
  localparam int FW = $clog2(NF);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_DQ    = 3'd2;
  localparam logic [2:0] S_RHEAD = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_LINK  = 3'd5;
  localparam logic [2:0] S_ENQ   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // Unpacked input fields.
  op_t   in_op;
  task_t in_tid;
  prio_t in_prio;
  prio_t in_newprio;

  assign in_op      = in_tdata[1:0];
  assign in_tid     = in_tdata[7:2];
  assign in_prio    = in_tdata[11:8];
  assign in_newprio = in_tdata[15:12];

  // Control registers.
  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] cur_p_r, cur_p_nxt;
  logic          enq_en_r, enq_en_nxt;
  stat_t         st_r, st_nxt;
  task_t         node_r, node_nxt;
  logic [CW-1:0] step_r, step_nxt;

  // Item registers captured on acceptance.
  op_t           op_r;
  task_t         tid_r;
  logic [PW-1:0] np_r;
  logic          bad_r;
  logic          tbad_r;
  logic          same_r;

  // Queue tables.
  task_t         head_r  [PRIORITY_LEVELS];
  task_t         tail_r  [PRIORITY_LEVELS];
  logic [CW-1:0] count_r [PRIORITY_LEVELS];

  // Queued-flag memory with a registered read port and a clearing pass after reset.
  logic          flag_mem [NF];
  logic          flag_q;
  logic          clr_busy_r;
  logic [FW-1:0] clr_idx_r;

  // Next-link memory with a registered read port.
  task_t         link_mem [TASK_SLOTS];
  task_t         link_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  task_t         wr_data;

  // Result path.
  logic          out_valid_r;
  stat_t         out_st_r;
  task_t         out_got_r;
  logic [CW-1:0] out_cnt_r;
  stat_t         hold_st_r;
  task_t         hold_got_r;
  logic [CW-1:0] hold_cnt_r;

  // Table update controls.
  logic          head_we, tail_we, cnt_we;
  task_t         head_wd, tail_wd;
  logic [CW-1:0] cnt_wd;
  logic          flag_set, flag_clr;
  logic [FW-1:0] flag_idx;

  // Finishing and shared sub-step controls.
  logic          fin;
  stat_t         fin_st;
  task_t         fin_got;
  logic [CW-1:0] fin_cnt;
  logic          rm_ok, rm_fail, do_put;

  logic          in_acc;
  logic          out_free;
  task_t         head_cur, tail_cur;
  logic [CW-1:0] cnt_cur;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] step_inc;
  logic [AW-1:0] tid_addr;

  assign in_tready = (state_r == S_IDLE) && !clr_busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign head_cur = head_r[cur_p_r];
  assign tail_cur = tail_r[cur_p_r];
  assign cnt_cur  = count_r[cur_p_r];
  assign cnt_dec  = cnt_cur - CW'(1);
  assign step_inc = step_r + CW'(1);
  assign tid_addr = AW'(tid_r);

  // Sequencer: one memory access per cycle, so reads never meet a write to the same entry.
  always_comb begin
    state_nxt  = state_r;
    cur_p_nxt  = cur_p_r;
    enq_en_nxt = enq_en_r;
    st_nxt     = st_r;
    node_nxt   = node_r;
    step_nxt   = step_r;
    rd_en      = 1'b0;
    rd_addr    = tid_addr;
    wr_en      = 1'b0;
    wr_addr    = AW'(tail_cur);
    wr_data    = tid_r;
    head_we    = 1'b0;
    head_wd    = link_q;
    tail_we    = 1'b0;
    tail_wd    = tid_r;
    cnt_we     = 1'b0;
    cnt_wd     = cnt_dec;
    flag_set   = 1'b0;
    flag_clr   = 1'b0;
    flag_idx   = FW'(tid_r);
    fin        = 1'b0;
    fin_st     = ST_OK;
    fin_got    = '0;
    fin_cnt    = cnt_cur;
    rm_ok      = 1'b0;
    rm_fail    = 1'b0;
    do_put     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DEC;
          cur_p_nxt = PW'(in_prio);
        end
      end

      S_DEC: begin
        if (bad_r) begin
          fin     = 1'b1;
          fin_st  = ST_BAD_PRIO;
          fin_cnt = '0;
        end else begin
          case (op_r)
            OP_ENQUEUE: begin
              if (tbad_r) begin
                fin    = 1'b1;
                fin_st = ST_NOT_FOUND;
              end else begin
                do_put = 1'b1;
              end
            end
            OP_DEQUEUE: begin
              if (cnt_cur == '0) begin
                fin    = 1'b1;
                fin_st = ST_NOT_FOUND;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(head_cur);
                node_nxt  = head_cur;
                state_nxt = S_DQ;
              end
            end
            default: begin
              if (op_r == OP_REMOVE && tbad_r) begin
                fin    = 1'b1;
                fin_st = ST_NOT_FOUND;
              end else if (op_r == OP_MOVE && (tbad_r || same_r)) begin
                // Nothing moves; report the count of the target queue.
                cur_p_nxt  = np_r;
                enq_en_nxt = 1'b0;
                st_nxt     = tbad_r ? ST_NOT_FOUND : ST_OK;
                state_nxt  = S_ENQ;
              end else if (cnt_cur == '0) begin
                rm_fail = 1'b1;
              end else if (head_cur == tid_r) begin
                rd_en     = 1'b1;
                rd_addr   = tid_addr;
                state_nxt = S_RHEAD;
              end else if (cnt_cur == CW'(1)) begin
                rm_fail = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(head_cur);
                node_nxt  = head_cur;
                step_nxt  = CW'(1);
                state_nxt = S_WALK;
              end
            end
          endcase
        end
      end

      // Take the head; an idle task found at the head is dropped and the walk goes on.
      S_DQ: begin
        head_we  = 1'b1;
        head_wd  = link_q;
        cnt_we   = 1'b1;
        cnt_wd   = cnt_dec;
        flag_clr = 1'b1;
        flag_idx = FW'(node_r);
        if (node_r != IDLE_TASK) begin
          fin     = 1'b1;
          fin_st  = ST_OK;
          fin_got = node_r;
          fin_cnt = cnt_dec;
        end else if (cnt_dec == '0) begin
          fin     = 1'b1;
          fin_st  = ST_NOT_FOUND;
          fin_cnt = '0;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = AW'(link_q);
          node_nxt = link_q;
        end
      end

      // The named task was the head.
      S_RHEAD: begin
        head_we = 1'b1;
        head_wd = link_q;
        cnt_we  = 1'b1;
        cnt_wd  = cnt_dec;
        rm_ok   = 1'b1;
      end

      // Follow one link per cycle, bounded by the queue's count.
      S_WALK: begin
        if (link_q == tid_r) begin
          rd_en     = 1'b1;
          rd_addr   = tid_addr;
          state_nxt = S_LINK;
        end else if (step_inc >= cnt_cur) begin
          rm_fail = 1'b1;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = AW'(link_q);
          node_nxt = link_q;
          step_nxt = step_inc;
        end
      end

      // Unlink the task behind its predecessor.
      S_LINK: begin
        wr_en   = 1'b1;
        wr_addr = AW'(node_r);
        wr_data = link_q;
        if (tail_cur == tid_r) begin
          tail_we = 1'b1;
          tail_wd = node_r;
        end
        cnt_we = 1'b1;
        cnt_wd = cnt_dec;
        rm_ok  = 1'b1;
      end

      S_ENQ: begin
        if (enq_en_r) begin
          do_put = 1'b1;
        end else begin
          fin    = 1'b1;
          fin_st = st_r;
        end
      end

      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Outcome of a removal, for a plain removal or the first half of a move.
    if (rm_ok || rm_fail) begin
      flag_clr = 1'b1;
      flag_idx = FW'(tid_r);
      if (op_r == OP_REMOVE) begin
        fin     = 1'b1;
        fin_st  = rm_ok ? ST_OK : ST_NOT_FOUND;
        fin_cnt = rm_ok ? cnt_dec : cnt_cur;
      end else begin
        cur_p_nxt  = np_r;
        enq_en_nxt = rm_ok;
        st_nxt     = ST_NOT_FOUND;
        state_nxt  = S_ENQ;
      end
    end

    // Append the task at the tail of the current queue. The flag read at acceptance
    // applies to a plain enqueue; in a move the removal has just cleared it.
    if (do_put) begin
      fin = 1'b1;
      if (tid_r == IDLE_TASK) begin
        fin_st = ST_IDLE;
      end else if ((flag_q && (state_r == S_DEC)) || (cnt_cur >= CW'(TASK_SLOTS))) begin
        fin_st = ST_QUEUED;
      end else begin
        fin_st = ST_OK;
        if (cnt_cur == '0) begin
          head_we = 1'b1;
          head_wd = tid_r;
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(tail_cur);
          wr_data = tid_r;
        end
        tail_we  = 1'b1;
        tail_wd  = tid_r;
        cnt_we   = 1'b1;
        cnt_wd   = cnt_cur + CW'(1);
        flag_set = 1'b1;
        fin_cnt  = cnt_cur + CW'(1);
      end
    end

    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_OUT;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      enq_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      enq_en_r <= enq_en_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    cur_p_r <= cur_p_nxt;
    st_r    <= st_nxt;
    node_r  <= node_nxt;
    step_r  <= step_nxt;
    if (in_acc) begin
      op_r   <= in_op;
      tid_r  <= in_tid;
      np_r   <= PW'(in_newprio);
      tbad_r <= (int'(in_tid) >= TASK_SLOTS);
      same_r <= (in_prio == in_newprio);
      if (in_op == OP_MOVE) begin
        bad_r <= (int'(in_prio) >= PRIORITY_LEVELS) || (int'(in_newprio) >= PRIORITY_LEVELS);
      end else begin
        bad_r <= (int'(in_prio) >= PRIORITY_LEVELS);
      end
    end
  end

  // Queue counts are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      if (cnt_we) begin
        count_r[cur_p_r] <= cnt_wd;
      end
    end
  end

  // Clearing pass over the queued flags, one entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == FW'(NF - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + FW'(1);
    end
  end

  // Queued-flag memory: one write port, read at acceptance of an item.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      flag_mem[clr_idx_r] <= 1'b0;
    end else if (flag_set || flag_clr) begin
      flag_mem[flag_idx] <= flag_set;
    end
    if (in_acc) begin
      flag_q <= flag_mem[FW'(in_tid)];
    end
  end

  // Head and tail pointers are only read while the queue's count is nonzero.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_r[cur_p_r] <= head_wd;
    end
    if (tail_we) begin
      tail_r[cur_p_r] <= tail_wd;
    end
  end

  // Next-link memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      link_q <= link_mem[rd_addr];
    end
  end

  // Output register, with a hold stage for a result finished while the output stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((fin || (state_r == S_OUT)) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && out_free) begin
      out_st_r  <= fin_st;
      out_got_r <= fin_got;
      out_cnt_r <= fin_cnt;
    end else if ((state_r == S_OUT) && out_free) begin
      out_st_r  <= hold_st_r;
      out_got_r <= hold_got_r;
      out_cnt_r <= hold_cnt_r;
    end
    if (fin && !out_free) begin
      hold_st_r  <= fin_st;
      hold_got_r <= fin_got;
      hold_cnt_r <= fin_cnt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {QCNT_W'(out_cnt_r), out_got_r, out_st_r};

endmodule

`default_nettype wire

@@ tb/tb_priority_run_queue_manager_top.sv @@
// Self-checking testbench for the priority run-queue manager, driven over its stream ports.
// A scoreboard class predicts every result from its own copy of the queues and compares it.
// Depends on rqm_pkg and priority_run_queue_manager_top.
`timescale 1ns / 1ps

module tb_priority_run_queue_manager_top;
  import rqm_pkg::*;

  localparam int LEVELS       = 8;
  localparam int SLOTS        = 64;
  localparam int RANDOM_ITEMS = 1800;
  localparam prio_t TOP_PRIO  = prio_t'(LEVELS - 1);

  // One predicted result item.
  typedef struct packed {
    stat_t      status;
    task_t      taken;
    logic [6:0] count;
  } outcome_t;

  // Predicts the queue manager and checks its results in order.
  class run_queue_checker;
    task_t       head_q[LEVELS];
    task_t       tail_q[LEVELS];
    int unsigned count_q[LEVELS];
    task_t       link[SLOTS];
    bit          queued[SLOTS];
    prio_t       home[SLOTS];
    outcome_t    pending_outcomes[$];
    int          errors;
    int          results_seen;
    int          status_seen[5];
    int unsigned deepest;

    function new();
      foreach (count_q[i]) begin
        head_q[i]  = IDLE_TASK;
        tail_q[i]  = IDLE_TASK;
        count_q[i] = 0;
      end
      foreach (link[i]) begin
        link[i]   = IDLE_TASK;
        queued[i] = 1'b0;
        home[i]   = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Appends a task at the tail of queue p.
    function stat_t link_tail(int p, task_t t);
      if (t == IDLE_TASK) return ST_IDLE;
      if (queued[t] || count_q[p] >= SLOTS) return ST_QUEUED;
      if (count_q[p] == 0) head_q[p] = t;
      else link[tail_q[p]] = t;
      tail_q[p] = t;
      count_q[p]++;
      queued[t] = 1'b1;
      home[t] = prio_t'(p);
      if (count_q[p] > deepest) deepest = count_q[p];
      return ST_OK;
    endfunction

    // Unlinks a task from queue p, walking no further than the queue's count.
    // The queued flag is cleared whether or not the task was found.
    function stat_t unlink_task(int p, task_t t);
      int unsigned n;
      task_t prev, nx;
      n = count_q[p];
      queued[t] = 1'b0;
      if (n == 0) return ST_NOT_FOUND;
      if (head_q[p] == t) begin
        head_q[p]  = link[t];
        count_q[p] = n - 1;
        return ST_OK;
      end
      prev = head_q[p];
      for (int unsigned i = 1; i < n; i++) begin
        nx = link[prev];
        if (nx == t) begin
          link[prev] = link[t];
          if (tail_q[p] == t) tail_q[p] = prev;
          count_q[p] = n - 1;
          return ST_OK;
        end
        prev = nx;
      end
      return ST_NOT_FOUND;
    endfunction

    // Works out the result of an accepted input item and stores it.
    function void note_item(logic [15:0] d);
      op_t      op;
      task_t    t, h;
      prio_t    p, np;
      outcome_t want;
      op = d[1:0];
      t  = d[7:2];
      p  = d[11:8];
      np = d[15:12];
      want = '{status: ST_OK, taken: IDLE_TASK, count: '0};
      case (op)
        OP_ENQUEUE, OP_REMOVE: begin
          if (p >= LEVELS) begin
            want.status = ST_BAD_PRIO;
          end else begin
            want.status = (op == OP_ENQUEUE) ? link_tail(int'(p), t)
                                             : unlink_task(int'(p), t);
            want.count  = 7'(count_q[p]);
          end
        end
        OP_DEQUEUE: begin
          if (p >= LEVELS) begin
            want.status = ST_BAD_PRIO;
          end else begin
            // An idle task found at the head is dropped before the real head is taken.
            while (count_q[p] != 0 && head_q[p] == IDLE_TASK)
              void'(unlink_task(int'(p), IDLE_TASK));
            if (count_q[p] == 0) begin
              want.status = ST_NOT_FOUND;
            end else begin
              h = head_q[p];
              if (unlink_task(int'(p), h) == ST_OK) want.taken = h;
              else want.status = ST_NOT_FOUND;
            end
            want.count = 7'(count_q[p]);
          end
        end
        default: begin
          if (p >= LEVELS || np >= LEVELS) begin
            want.status = ST_BAD_PRIO;
          end else begin
            // A move to the same level changes nothing.
            if (p != np) begin
              want.status = unlink_task(int'(p), t);
              if (want.status == ST_OK) want.status = link_tail(int'(np), t);
            end
            want.count = 7'(count_q[np]);
          end
        end
      endcase
      status_seen[want.status]++;
      pending_outcomes.push_back(want);
    endfunction

    // Compares one accepted result item with the oldest prediction.
    task check_result(logic [15:0] d);
      outcome_t want;
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", d));
        return;
      end
      want = pending_outcomes.pop_front();
      if (d[2:0] !== want.status)
        report($sformatf("status %0d, expected %0d", d[2:0], want.status));
      if (d[8:3] !== want.taken)
        report($sformatf("out_task %0d, expected %0d", d[8:3], want.taken));
      if (d[15:9] !== want.count)
        report($sformatf("queue_count %0d, expected %0d", d[15:9], want.count));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;

  run_queue_checker board;
  int send_idle  = 0;
  int recv_stall = 0;
  int items_sent = 0;
  int opening_items;

  priority_run_queue_manager_top #(
    .PRIORITY_LEVELS(LEVELS),
    .TASK_SLOTS     (SLOTS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] pack(op_t op, task_t t, prio_t p, prio_t np);
    return {np, p, t, op};
  endfunction

  // Offers one item, idling beforehand at the current rate, and returns once it is accepted.
  task automatic send_item(input logic [15:0] d);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    board.note_item(d);
    items_sent++;
  endtask

  // Holds the sender back until every outstanding result has come.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_outcomes.size() != 0);
  endtask

  // Mostly well-formed traffic: enqueues of free tasks, dequeues, and removals or moves of
  // queued tasks from their own level. The rest is raw noise over every bit.
  function automatic logic [15:0] random_item();
    int    roll;
    task_t t;
    prio_t p, np;
    roll = $urandom_range(99);
    t    = task_t'($urandom_range(SLOTS - 1, 1));
    p    = prio_t'($urandom_range(LEVELS - 1));
    np   = prio_t'($urandom_range(LEVELS - 1));
    if (roll < 12) return 16'($urandom);
    if (roll < 45) begin
      for (int k = 0; k < 4 && board.queued[t]; k++) t = task_t'($urandom_range(SLOTS - 1, 1));
      return pack(OP_ENQUEUE, t, p, np);
    end
    if (roll < 65) return pack(OP_DEQUEUE, t, p, np);
    for (int k = 0; k < 8 && !board.queued[t]; k++) t = task_t'($urandom_range(SLOTS - 1, 1));
    if (board.queued[t]) p = board.home[t];
    return pack((roll < 80) ? OP_REMOVE : OP_MOVE, t, p, np);
  endfunction

  // Result side: checks each accepted item and stalls at the current rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Stimulus and end of run.
  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the top level with every non-idle task so that each of their link entries gets written, then
    // rotate the head to the tail so the last task's link is written too.
    for (int k = 1; k < SLOTS; k++) send_item(pack(OP_ENQUEUE, task_t'(k), TOP_PRIO, '0));
    send_item(pack(OP_REMOVE, task_t'(1), TOP_PRIO, '0));
    send_item(pack(OP_ENQUEUE, task_t'(1), TOP_PRIO, '0));

    // Directed cases against the deep queue.
    send_item(pack(OP_ENQUEUE, task_t'(5), TOP_PRIO, '0));          // already queued
    send_item(pack(OP_ENQUEUE, IDLE_TASK, prio_t'(3), '0));         // idle task refused
    send_item(pack(OP_ENQUEUE, task_t'(10), prio_t'(LEVELS), '0));  // first bad level
    send_item(pack(OP_DEQUEUE, '1, '1, '1));                        // highest bad level
    send_item(pack(OP_REMOVE, task_t'(63), TOP_PRIO, '0));          // long walk, old tail
    send_item(pack(OP_REMOVE, task_t'(2), TOP_PRIO, '0));           // head removal
    send_item(pack(OP_REMOVE, task_t'(2), TOP_PRIO, '0));           // full walk, not found
    send_item(pack(OP_MOVE, task_t'(1), TOP_PRIO, '0));             // tail moves to level 0
    send_item(pack(OP_MOVE, task_t'(3), TOP_PRIO, TOP_PRIO));       // same level
    send_item(pack(OP_MOVE, task_t'(3), TOP_PRIO, prio_t'(9)));     // bad target level
    send_item(pack(OP_MOVE, task_t'(3), '1, '0));                   // bad source level
    send_item(pack(OP_MOVE, IDLE_TASK, TOP_PRIO, prio_t'(1)));      // removal fails
    send_item(pack(OP_REMOVE, IDLE_TASK, TOP_PRIO, '0));
    send_item(pack(OP_DEQUEUE, '0, '0, '0));                        // takes task 1
    send_item(pack(OP_DEQUEUE, '0, '0, '0));                        // empty queue
    send_item(pack(OP_REMOVE, task_t'(1), '0, '0));                 // empty queue
    send_item(pack(OP_MOVE, task_t'(1), '0, prio_t'(2)));           // removal from empty
    send_item(pack(OP_ENQUEUE, '1, '0, '0));                        // highest task id
    send_item(pack(OP_MOVE, '1, '0, TOP_PRIO));
    while (board.count_q[LEVELS - 1] != 0) send_item(pack(OP_DEQUEUE, '0, TOP_PRIO, '0));
    send_item(pack(OP_DEQUEUE, '1, TOP_PRIO, '1));
    wait_drained();
    opening_items = items_sent;

    // Random traffic in four flow-control phases, draining fully between them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 75; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 75; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      repeat (RANDOM_ITEMS / 4) send_item(random_item());
      wait_drained();
    end

    // Allow a stray late result to show up.
    recv_stall = 0;
    repeat (100) @(posedge clk);
    if (board.pending_outcomes.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending_outcomes.size()));
    $display("Covered %0d items (%0d in the opening sequences), %0d results checked.",
             items_sent, opening_items, board.results_seen);
    $display("Outcomes: %0d ok, %0d bad level, %0d idle, %0d queued, %0d not found; deepest %0d.",
             board.status_seen[ST_OK], board.status_seen[ST_BAD_PRIO],
             board.status_seen[ST_IDLE], board.status_seen[ST_QUEUED],
             board.status_seen[ST_NOT_FOUND], board.deepest);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rqm_pkg.sv
rtl/priority_run_queue_manager_top.sv
tb/tb_priority_run_queue_manager_top.sv
